@@ design/dmft_pkg.sv @@
// shared types and constants of the direct-mapped flow tracker
package dmft_pkg;

  // stream and configuration widths
  localparam int unsigned IN_TDATA_W  = 272;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned BUCKET_W    = 9;

  // hash constants
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  // register reset values
  localparam logic [31:0] PKT_LIMIT_RESET  = 32'd24;
  localparam logic [31:0] BYTE_LIMIT_RESET = 32'd14000;
  localparam logic [39:0] AGE_LIMIT_RESET  = 40'd12000000000;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PACKET_LIMIT = 2'd0,
    REG_BYTE_LIMIT   = 2'd1,
    REG_AGE_LIMIT    = 2'd2
  } cfg_reg_t;

  // input beat, last field (src_addr) in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [63:0] flow_age_ns;
    logic [63:0] byte_total;
    logic [31:0] packet_total;
    logic        checkpoint_eligible;
    logic        fin_or_rst;
    logic [7:0]  protocol;
    logic [15:0] dst_port;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [31:0] src_addr;
  } in_beat_t;

  // output beat, last field (bucket_index) in the lowest bits
  typedef struct packed {
    logic [2:0]          pad;
    logic                run_checkpoint;
    logic                evicted;
    logic                new_flow;
    logic                from_initiator;
    logic [BUCKET_W-1:0] bucket_index;
  } out_beat_t;

  // one table bucket
  typedef struct packed {
    logic        valid;
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [31:0] origin_addr;
    logic [15:0] origin_port;
    logic        scored;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic clr_en;
    logic hash_en;
    logic mod_en;
    logic rd_en;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic mod_last;
    logic out_busy;
  } sts_t;

endpackage

@@ design/direct_mapped_flow_tracker_core.sv @@
// Direct-mapped flow tracker: one packet header in, one bucket report out. The
// endpoints are put in canonical order, hashed with word-wise FNV-1a over four
// words (one 32x32 multiply per cycle on a shared multiplier) and reduced to a
// bucket of a BUCKET_COUNT-deep table that is read and rewritten once per packet.
// A packet passes from acceptance to result through accept, 4 hash steps,
// reduce, table read and update; when BUCKET_COUNT is a power of two the
// reduce is a mask, otherwise a remainder by reciprocal multiply,
// multiply-subtract and one correcting subtract. One packet is in the datapath at
// a time, and the next is accepted as soon as the previous result sits in the
// output register. After reset the table is cleared one bucket per cycle over
// all BUCKET_COUNT buckets, during which s_axis_tready stays low; configuration
// writes are taken at any time.
module direct_mapped_flow_tracker_core #(
  parameter int unsigned BUCKET_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // packet beats
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // src_addr, src_port, dst_addr, dst_port, protocol, fin_or_rst,
  // checkpoint_eligible, packet_total, byte_total, flow_age_ns, zero pad
  input  logic [dmft_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // report beats
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // bucket_index, from_initiator, new_flow, evicted, run_checkpoint, zero pad
  output logic [dmft_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dmft_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dmft_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dmft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  // controller
  dmft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  dmft_datapath #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one packet in flight: an accepted beat is followed by a cycle without ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a packet is in flight");

  // a report is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("report overwritten before it was taken");

  // every update shows up as a report beat
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_axis_tvalid)
    else $error("update without a report beat");

  // the clearing sweep runs right after reset
  a_clear_first: assert property (@(posedge clk)
    $fell(rst) |-> (!s_axis_tready && cmd.clr_en))
    else $error("table not being cleared after reset");

endmodule

@@ design/dmft_ctrl.sv @@
// controller state machine of the flow tracker
module dmft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dmft_pkg::sts_t sts,
  output dmft_pkg::cmd_t cmd
);
  import dmft_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_HASH;
      S_HASH:   if (sts.hash_last) state_next = S_MOD;
      S_MOD:    if (sts.mod_last) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: if (!sts.out_busy) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.clr_en   = (state == S_CLEAR);
    cmd.in_ready = (state == S_IDLE);
    cmd.hash_en  = (state == S_HASH);
    cmd.mod_en   = (state == S_MOD);
    cmd.rd_en    = (state == S_READ);
    cmd.commit   = (state == S_UPDATE) && !sts.out_busy;
  end

endmodule

@@ design/dmft_datapath.sv @@
// datapath of the flow tracker: key ordering, hash, bucket table, result register
module dmft_datapath #(
  parameter int unsigned BUCKET_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dmft_pkg::cmd_t                        cmd,
  output dmft_pkg::sts_t                        sts,
  input  logic                                 in_valid,
  input  logic [dmft_pkg::IN_TDATA_W-1:0]      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dmft_pkg::OUT_TDATA_W-1:0]     out_data,
  input  logic                                 cfg_valid,
  input  logic [dmft_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dmft_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dmft_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUCKET_COUNT);

  // configuration
  logic [31:0] packet_limit;
  logic [31:0] byte_limit;
  logic [39:0] age_limit_ns;

  // captured packet
  logic [31:0] lo_addr, hi_addr, ports, src_addr;
  logic [15:0] src_port;
  logic [7:0]  proto;
  logic        trig, elig;

  // hash
  logic [31:0] h, h_next, hash_word;
  logic [1:0]  hash_cnt;
  logic [IDX_W-1:0] bucket;
  logic        mod_last;

  // table
  entry_t      mem [BUCKET_COUNT];
  entry_t      rd_entry;
  entry_t      wr_entry;
  logic [IDX_W-1:0] clr_cnt;

  // update decision
  in_beat_t    beat;
  out_beat_t   result;
  logic        load, src_first, hit, scored_old, run;
  logic [31:0] origin_addr;
  logic [15:0] origin_port;

  assign beat = in_beat_t'(in_data);
  assign load = in_valid && cmd.in_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_limit <= PKT_LIMIT_RESET;
      byte_limit   <= BYTE_LIMIT_RESET;
      age_limit_ns <= AGE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PACKET_LIMIT: packet_limit <= cfg_data[31:0];
        REG_BYTE_LIMIT:   byte_limit   <= cfg_data[31:0];
        REG_AGE_LIMIT:    age_limit_ns <= cfg_data;
        default:          ;
      endcase
    end
  end

  // canonical endpoint order, lower address first, then lower port
  assign src_first = (beat.src_addr != beat.dst_addr) ? (beat.src_addr < beat.dst_addr)
                                                      : (beat.src_port <= beat.dst_port);

  // capture key and triggers
  always_ff @(posedge clk) begin
    if (load) begin
      lo_addr  <= src_first ? beat.src_addr : beat.dst_addr;
      hi_addr  <= src_first ? beat.dst_addr : beat.src_addr;
      ports    <= src_first ? {beat.src_port, beat.dst_port} : {beat.dst_port, beat.src_port};
      proto    <= beat.protocol;
      src_addr <= beat.src_addr;
      src_port <= beat.src_port;
      elig     <= beat.checkpoint_eligible;
      trig     <= beat.fin_or_rst
               || (beat.packet_total >= packet_limit)
               || (beat.byte_total >= {32'd0, byte_limit})
               || (beat.flow_age_ns >= {24'd0, age_limit_ns});
    end
  end

  // one fnv-1a word per cycle through a shared multiplier
  always_comb begin
    unique case (hash_cnt)
      2'd0:    hash_word = lo_addr;
      2'd1:    hash_word = hi_addr;
      2'd2:    hash_word = ports;
      default: hash_word = {24'd0, proto};
    endcase
  end

  assign h_next = 32'((h ^ hash_word) * FNV_PRIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_cnt <= 2'd0;
    end else if (load) begin
      hash_cnt <= 2'd0;
    end else if (cmd.hash_en) begin
      hash_cnt <= hash_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h <= FNV_OFFSET;
    end else if (cmd.hash_en) begin
      h <= h_next;
    end
  end

  // bucket from hash: mask for a power of two, else reciprocal remainder with correction
  if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_mask
    assign bucket   = h[IDX_W-1:0];
    assign mod_last = 1'b1;
  end else begin : g_rem
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / BUCKET_COUNT);
    localparam logic [31:0] DIVISOR = 32'(BUCKET_COUNT);

    logic [31:0]      num, quot, rem_wide, rem_fix;
    logic [63:0]      prod;
    logic [IDX_W-1:0] rem;
    logic [1:0]       mod_cnt;

    // quotient estimate is exact or one short, so one correcting subtract is enough
    assign prod    = 64'(num) * 64'(RECIP);
    assign rem_fix = (rem_wide >= DIVISOR) ? (rem_wide - DIVISOR) : rem_wide;

    always_ff @(posedge clk) begin
      if (rst) begin
        mod_cnt <= 2'd0;
      end else if (load) begin
        mod_cnt <= 2'd0;
      end else if (cmd.mod_en) begin
        mod_cnt <= mod_cnt + 2'd1;
      end
    end

    // estimate, multiply-subtract, correct
    always_ff @(posedge clk) begin
      if (cmd.hash_en && (hash_cnt == 2'd3)) begin
        num <= h_next;
      end
      if (cmd.mod_en) begin
        unique case (mod_cnt)
          2'd0:    quot     <= prod[63:32];
          2'd1:    rem_wide <= num - 32'(quot * DIVISOR);
          2'd2:    rem      <= rem_fix[IDX_W-1:0];
          default: ;
        endcase
      end
    end

    assign bucket   = rem;
    assign mod_last = (mod_cnt == 2'd2);
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // bucket lookup and replacement
  assign hit = rd_entry.valid && (rd_entry.lo_addr == lo_addr) && (rd_entry.hi_addr == hi_addr)
            && (rd_entry.ports == ports) && (rd_entry.proto == proto);
  assign origin_addr = hit ? rd_entry.origin_addr : src_addr;
  assign origin_port = hit ? rd_entry.origin_port : src_port;
  assign scored_old  = hit && rd_entry.scored;
  assign run         = elig && !scored_old && trig;

  always_comb begin
    wr_entry.valid       = 1'b1;
    wr_entry.lo_addr     = lo_addr;
    wr_entry.hi_addr     = hi_addr;
    wr_entry.ports       = ports;
    wr_entry.proto       = proto;
    wr_entry.origin_addr = origin_addr;
    wr_entry.origin_port = origin_port;
    wr_entry.scored      = scored_old || run;
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.commit) begin
      mem[bucket] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_entry <= mem[bucket];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.pad            <= '0;
      result.bucket_index   <= BUCKET_W'(bucket);
      result.from_initiator <= (origin_addr == src_addr) && (origin_port == src_port);
      result.new_flow       <= !hit;
      result.evicted        <= !hit && rd_entry.valid;
      result.run_checkpoint <= run;
    end
  end

  assign out_data = OUT_TDATA_W'(result);

  // status
  assign sts.clr_last  = (clr_cnt == IDX_W'(BUCKET_COUNT - 1));
  assign sts.hash_last = (hash_cnt == 2'd3);
  assign sts.mod_last  = mod_last;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

@@ test/direct_mapped_flow_tracker_checker.sv @@
// scoreboard of the flow tracker: predicts every report beat and compares it with the block
module direct_mapped_flow_tracker_checker #(
  parameter int unsigned BUCKET_COUNT = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [dmft_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [dmft_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [dmft_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmft_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      fail_count,
  output int unsigned                      reports_pending,
  output int unsigned                      reports_checked,
  output int unsigned                      new_flows,
  output int unsigned                      evictions,
  output int unsigned                      checkpoints
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmft_pkg::*;

  // one predicted report beat
  typedef struct packed {
    logic [BUCKET_W-1:0] bucket_index;
    logic                from_initiator;
    logic                new_flow;
    logic                evicted;
    logic                run_checkpoint;
  } flow_report_t;

  // shadow copy of the bucket table
  logic        slot_valid       [BUCKET_COUNT];
  logic [31:0] slot_lo_addr     [BUCKET_COUNT];
  logic [31:0] slot_hi_addr     [BUCKET_COUNT];
  logic [31:0] slot_ports       [BUCKET_COUNT];
  logic [7:0]  slot_proto       [BUCKET_COUNT];
  logic [31:0] slot_origin_addr [BUCKET_COUNT];
  logic [15:0] slot_origin_port [BUCKET_COUNT];
  logic        slot_scored      [BUCKET_COUNT];

  // shadow copy of the checkpoint limits
  logic [31:0] lim_packets;
  logic [31:0] lim_bytes;
  logic [39:0] lim_age;

  flow_report_t expected_reports [$];
  flow_report_t want;
  out_beat_t    got;

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val)
      report_failure($sformatf("report %0d field %s: expected %0d, got %0d",
                               reports_checked, name, exp_val, act_val));
  endtask

  // bucket lookup, install and checkpoint decision for one packet
  function automatic flow_report_t track_packet(input in_beat_t pkt);
    logic         src_first;
    logic [31:0]  lo_addr;
    logic [31:0]  hi_addr;
    logic [15:0]  lo_port;
    logic [15:0]  hi_port;
    logic [31:0]  port_pair;
    logic [31:0]  hash;
    int unsigned  b;
    logic         hit;
    logic         trig;
    flow_report_t rep;
    // canonical endpoint order, equal ports keep packet order
    src_first = (pkt.src_addr != pkt.dst_addr) ? (pkt.src_addr < pkt.dst_addr)
                                               : (pkt.src_port <= pkt.dst_port);
    lo_addr   = src_first ? pkt.src_addr : pkt.dst_addr;
    hi_addr   = src_first ? pkt.dst_addr : pkt.src_addr;
    lo_port   = src_first ? pkt.src_port : pkt.dst_port;
    hi_port   = src_first ? pkt.dst_port : pkt.src_port;
    port_pair = {lo_port, hi_port};
    // word-wise fnv-1a over the key
    hash = FNV_OFFSET;
    hash = (hash ^ lo_addr) * FNV_PRIME;
    hash = (hash ^ hi_addr) * FNV_PRIME;
    hash = (hash ^ port_pair) * FNV_PRIME;
    hash = (hash ^ {24'd0, pkt.protocol}) * FNV_PRIME;
    b = hash % BUCKET_COUNT;
    hit = slot_valid[b] && slot_lo_addr[b] == lo_addr && slot_hi_addr[b] == hi_addr &&
          slot_ports[b] == port_pair && slot_proto[b] == pkt.protocol;
    rep.new_flow = !hit;
    rep.evicted  = !hit && slot_valid[b];
    // miss installs the flow with this packet's source as initiator
    if (!hit) begin
      slot_valid[b]       = 1'b1;
      slot_lo_addr[b]     = lo_addr;
      slot_hi_addr[b]     = hi_addr;
      slot_ports[b]       = port_pair;
      slot_proto[b]       = pkt.protocol;
      slot_origin_addr[b] = pkt.src_addr;
      slot_origin_port[b] = pkt.src_port;
      slot_scored[b]      = 1'b0;
    end
    rep.from_initiator = slot_origin_addr[b] == pkt.src_addr &&
                         slot_origin_port[b] == pkt.src_port;
    // one-time checkpoint
    trig = pkt.fin_or_rst || pkt.packet_total >= lim_packets ||
           pkt.byte_total >= {32'd0, lim_bytes} || pkt.flow_age_ns >= {24'd0, lim_age};
    rep.run_checkpoint = pkt.checkpoint_eligible && !slot_scored[b] && trig;
    if (rep.run_checkpoint)
      slot_scored[b] = 1'b1;
    rep.bucket_index = BUCKET_W'(b);
    return rep;
  endfunction

  // watch the three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        slot_valid[i]  = 1'b0;
        slot_scored[i] = 1'b0;
      end
      lim_packets = PKT_LIMIT_RESET;
      lim_bytes   = BYTE_LIMIT_RESET;
      lim_age     = AGE_LIMIT_RESET;
      expected_reports.delete();
      fail_count      = 0;
      reports_checked = 0;
      new_flows       = 0;
      evictions       = 0;
      checkpoints     = 0;
    end else begin
      // register writes, unknown index ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PACKET_LIMIT: lim_packets = cfg_data[31:0];
          REG_BYTE_LIMIT:   lim_bytes   = cfg_data[31:0];
          REG_AGE_LIMIT:    lim_age     = cfg_data[39:0];
          default: ;
        endcase
      end
      // packet beat in
      if (s_axis_tvalid && s_axis_tready) begin
        want = track_packet(in_beat_t'(s_axis_tdata));
        expected_reports.push_back(want);
        new_flows   += want.new_flow;
        evictions   += want.evicted;
        checkpoints += want.run_checkpoint;
      end
      // report beat out
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_beat_t'(m_axis_tdata);
        if (expected_reports.size() == 0) begin
          report_failure($sformatf("report beat %h with none expected", m_axis_tdata));
        end else begin
          want = expected_reports.pop_front();
          compare_field("bucket_index", want.bucket_index, got.bucket_index);
          compare_field("from_initiator", want.from_initiator, got.from_initiator);
          compare_field("new_flow", want.new_flow, got.new_flow);
          compare_field("evicted", want.evicted, got.evicted);
          compare_field("run_checkpoint", want.run_checkpoint, got.run_checkpoint);
        end
        reports_checked++;
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

@@ test/tb_direct_mapped_flow_tracker_core.sv @@
// stimulus and verdict for the direct-mapped flow tracker
module tb_direct_mapped_flow_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dmft_pkg::*;

  localparam int unsigned BUCKET_COUNT = 512;
  localparam int unsigned POOL_SIZE    = 48;

  // register index the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SPARE = 2'd3;

  // protocol numbers used in directed packets
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // hosts used in directed packets
  localparam logic [31:0] HOST_A = 32'h0A00_0001;
  localparam logic [31:0] HOST_B = 32'h0A00_0002;
  localparam logic [31:0] HOST_C = 32'hC0A8_0105;
  localparam logic [31:0] HOST_D = 32'h0707_0707;
  localparam logic [31:0] HOST_E = 32'h8000_0000;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_BURSTY} rx_style_t;

  typedef struct {
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [7:0]  proto;
  } flow_key_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned fail_count;
  int unsigned reports_pending;
  int unsigned reports_checked;
  int unsigned new_flows;
  int unsigned evictions;
  int unsigned checkpoints;

  logic [31:0] cur_pkt_limit  = PKT_LIMIT_RESET;
  logic [31:0] cur_byte_limit = BYTE_LIMIT_RESET;
  logic [39:0] cur_age_limit  = AGE_LIMIT_RESET;
  int unsigned settings_used  = 1;
  int unsigned packets_sent   = 0;
  int unsigned burst_left     = 0;
  flow_key_t   flow_pool [POOL_SIZE];

  rx_style_t   rx_style = RX_STREAM;
  int unsigned rx_cycle = 0;
  int unsigned rx_hold  = 0;

  always #6 clk = ~clk;

  direct_mapped_flow_tracker_core #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  direct_mapped_flow_tracker_checker #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .reports_pending(reports_pending),
    .reports_checked(reports_checked),
    .new_flows      (new_flows),
    .evictions      (evictions),
    .checkpoints    (checkpoints)
  );

  // report receiver, periodically picks a new stall style at random
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 150 == 0)
      rx_style = rx_style_t'($urandom_range(0, 2));
    case (rx_style)
      RX_STREAM: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0)
            rx_hold = $urandom_range(1, 20);
        end
      end
    endcase
  end

  function automatic in_beat_t make_packet(
    input logic [31:0] sa, input logic [15:0] sp,
    input logic [31:0] da, input logic [15:0] dp,
    input logic [7:0]  proto, input logic fin, input logic elig,
    input logic [31:0] pkts, input logic [63:0] bytes, input logic [63:0] age);
    in_beat_t p;
    p.pad                 = '0;
    p.src_addr            = sa;
    p.src_port            = sp;
    p.dst_addr            = da;
    p.dst_port            = dp;
    p.protocol            = proto;
    p.fin_or_rst          = fin;
    p.checkpoint_eligible = elig;
    p.packet_total        = pkts;
    p.byte_total          = bytes;
    p.flow_age_ns         = age;
    return p;
  endfunction

  // flow total: around the limit, anywhere, small, or an extreme
  function automatic logic [63:0] pick_total(input logic [63:0] limit);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = limit - 64'd2 + 64'($urandom_range(0, 4));
      2:       v = {$urandom, $urandom};
      3:       v = 64'($urandom_range(0, 200));
      4:       v = '0;
      default: v = '1;
    endcase
    return v;
  endfunction

  // new 5-tuple, sometimes with equal addresses or equal ports
  function automatic flow_key_t fresh_flow();
    flow_key_t f;
    f.addr_a = $urandom;
    f.addr_b = ($urandom_range(0, 7) == 0) ? f.addr_a : $urandom;
    f.port_a = 16'($urandom);
    f.port_b = ($urandom_range(0, 7) == 0) ? f.port_a : 16'($urandom);
    case ($urandom_range(0, 3))
      0:       f.proto = PROTO_TCP;
      1:       f.proto = PROTO_UDP;
      2:       f.proto = PROTO_ICMP;
      default: f.proto = 8'($urandom);
    endcase
    return f;
  endfunction

  // one packet beat in bursts with random gaps, called at a falling edge
  task automatic send_paced(input in_beat_t pkt);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pkt;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    packets_sent++;
  endtask

  // stop sending and let every expected report come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // all three limits, junk above the 32-bit ones, then a write to the spare index
  task automatic write_limits(input logic [31:0] pkt_lim, input logic [31:0] byte_lim,
                              input logic [39:0] age_lim);
    write_one(REG_PACKET_LIMIT, {8'($urandom), pkt_lim});
    write_one(REG_BYTE_LIMIT, {8'($urandom), byte_lim});
    write_one(REG_AGE_LIMIT, age_lim);
    write_one(REG_INDEX_SPARE, {8'($urandom), 32'($urandom)});
    cfg_valid <= 1'b0;
    cur_pkt_limit  = pkt_lim;
    cur_byte_limit = byte_lim;
    cur_age_limit  = age_lim;
    settings_used++;
  endtask

  // random packets, mostly both directions of pooled flows
  task automatic run_random(input int unsigned count);
    flow_key_t   f;
    int unsigned slot;
    logic        fin;
    logic        elig;
    logic [63:0] pkts;
    logic [63:0] bytes;
    logic [63:0] age;
    repeat (count) begin
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 4) == 0)
        flow_pool[slot] = fresh_flow();
      f     = flow_pool[slot];
      fin   = ($urandom_range(0, 9) == 0);
      elig  = ($urandom_range(0, 3) != 0);
      pkts  = pick_total(64'(cur_pkt_limit));
      bytes = pick_total(64'(cur_byte_limit));
      age   = pick_total(64'(cur_age_limit));
      if ($urandom_range(0, 1) == 1)
        send_paced(make_packet(f.addr_b, f.port_b, f.addr_a, f.port_a, f.proto,
                               fin, elig, pkts[31:0], bytes, age));
      else
        send_paced(make_packet(f.addr_a, f.port_a, f.addr_b, f.port_b, f.proto,
                               fin, elig, pkts[31:0], bytes, age));
    end
  endtask

  // run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++)
      flow_pool[i] = fresh_flow();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packets under the reset limits
    send_paced(make_packet('0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0, '0));
    send_paced(make_packet('1, '1, '1, '1, '1, 1'b1, 1'b1, '1, '1, '1));
    send_paced(make_packet('1, '1, '1, '1, '1, 1'b1, 1'b1, '1, '1, '1));
    // both directions of one tcp flow, packet limit reached, checkpoint run once
    send_paced(make_packet(HOST_A, 16'd1234, HOST_B, 16'd80, PROTO_TCP, 1'b0, 1'b1,
                           32'd1, 64'd60, 64'd0));
    send_paced(make_packet(HOST_B, 16'd80, HOST_A, 16'd1234, PROTO_TCP, 1'b0, 1'b1,
                           PKT_LIMIT_RESET - 1, 64'(BYTE_LIMIT_RESET) - 1,
                           64'(AGE_LIMIT_RESET) - 1));
    send_paced(make_packet(HOST_A, 16'd1234, HOST_B, 16'd80, PROTO_TCP, 1'b0, 1'b1,
                           PKT_LIMIT_RESET, 64'd900, 64'd5));
    send_paced(make_packet(HOST_B, 16'd80, HOST_A, 16'd1234, PROTO_TCP, 1'b1, 1'b1,
                           32'd30, 64'd1000, 64'd6));
    // equal addresses, ordered by port; fin on an ineligible packet
    send_paced(make_packet(HOST_C, 16'd5000, HOST_C, 16'd4000, PROTO_UDP, 1'b1, 1'b0,
                           32'd1, 64'd10, 64'd0));
    send_paced(make_packet(HOST_C, 16'd4000, HOST_C, 16'd5000, PROTO_UDP, 1'b0, 1'b1,
                           32'd2, 64'(BYTE_LIMIT_RESET) - 1, 64'd1));
    send_paced(make_packet(HOST_C, 16'd5000, HOST_C, 16'd4000, PROTO_UDP, 1'b0, 1'b1,
                           32'd3, 64'(BYTE_LIMIT_RESET), 64'd2));
    // identical endpoints, age limit crossed
    send_paced(make_packet(HOST_D, 16'd53, HOST_D, 16'd53, PROTO_UDP, 1'b0, 1'b1,
                           32'd1, 64'd80, 64'(AGE_LIMIT_RESET) - 1));
    send_paced(make_packet(HOST_D, 16'd53, HOST_D, 16'd53, PROTO_UDP, 1'b0, 1'b1,
                           32'd2, 64'd160, 64'(AGE_LIMIT_RESET)));
    // protocol alone tells two flows apart
    send_paced(make_packet(HOST_E, 16'd0, HOST_A, 16'd0, PROTO_ICMP, 1'b1, 1'b1,
                           32'd1, 64'd64, 64'd0));
    send_paced(make_packet(HOST_E, 16'd0, HOST_A, 16'd0, PROTO_ICMPV6, 1'b0, 1'b1,
                           32'd1, 64'd64, 64'd0));
    send_paced(make_packet(HOST_A, 16'd0, HOST_E, 16'd0, PROTO_ICMPV6, 1'b0, 1'b0,
                           '1, 64'd64, 64'd0));
    send_paced(make_packet(HOST_A, 16'd0, HOST_E, 16'd0, PROTO_ICMPV6, 1'b0, 1'b1,
                           '1, 64'd64, 64'd0));

    // random phases over zero, maximum, random and reset limits
    wait_drained();
    write_limits('0, '0, '0);
    run_random(220);
    wait_drained();
    write_limits('1, '1, '1);
    run_random(220);
    wait_drained();
    write_limits($urandom_range(1, 64), $urandom_range(1, 100000),
                 {8'($urandom), 32'($urandom)});
    run_random(280);
    wait_drained();
    write_limits(PKT_LIMIT_RESET, BYTE_LIMIT_RESET, AGE_LIMIT_RESET);
    run_random(280);

    wait_drained();
    repeat (16) @(negedge clk);
    $display("covered %0d packets under %0d limit settings, %0d reports checked",
             packets_sent, settings_used, reports_checked);
    $display("flows installed %0d, evictions %0d, checkpoints %0d",
             new_flows, evictions, checkpoints);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
